// ===== hdl/data_run_list_decoder_macros.svh =====
// assertion macros shared by the data-run list decoder
`ifndef DATA_RUN_LIST_DECODER_MACROS_SVH
`define DATA_RUN_LIST_DECODER_MACROS_SVH

// same-cycle implication, checked outside reset
`define DRL_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("data run list decoder: same-cycle check failed");

// next-cycle implication, checked outside reset
`define DRL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("data run list decoder: next-cycle check failed");

`endif

// ===== hdl/drl_pkg.sv =====
// types, constants and helpers of the data-run list decoder
package drl_pkg;

  localparam int unsigned MAX_FIELD_BYTES = 8;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned WORD_W   = 64;
  localparam int unsigned SPC_W    = 8;
  localparam int unsigned BPS_W    = 13;
  localparam int unsigned SCALE_W  = SPC_W + BPS_W;
  localparam int unsigned CHUNK_W  = 16;
  localparam int unsigned PROD_W   = CHUNK_W + SCALE_W;
  localparam int unsigned NCHUNK   = WORD_W / CHUNK_W;
  localparam int unsigned SIZE_W   = 4;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 13;

  localparam logic [BYTE_W-1:0] HDR_LEN_MASK = 8'h0F;
  localparam logic [BYTE_W-1:0] HDR_OFF_MASK = 8'hF0;

  localparam logic [SPC_W-1:0] SPC_RESET = 8'd8;
  localparam logic [BPS_W-1:0] BPS_RESET = 13'd512;

  localparam logic [CFG_IDX_W-1:0] REG_SECTORS_PER_CLUSTER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BYTES_PER_SECTOR    = 2'd1;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_LENGTH = 2'd1,
    PH_OFFSET = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_MUL  = 2'd1,
    S_OFF  = 2'd2,
    S_EMIT = 2'd3
  } seq_state_t;

  typedef enum logic [1:0] {
    RES_RUN = 2'd0,
    RES_END = 2'd1,
    RES_ERR = 2'd2
  } res_kind_t;

  typedef enum logic [1:0] {
    ADD_NONE   = 2'd0,
    ADD_MAC    = 2'd1,
    ADD_OFFSET = 2'd2
  } add_op_t;

  typedef struct packed {
    logic       acc_clr;
    logic       mul_en;
    logic [1:0] mul_sel;
    add_op_t    add_op;
  } unit_ctl_t;

  // sign-extend an n-byte little-endian offset, n = 8 and n = 0 pass through
  function automatic logic [WORD_W-1:0] sign_extend(input logic [WORD_W-1:0] off,
                                                    input logic [SIZE_W-1:0] n);
    logic [5:0]        top_bit;
    logic [5:0]        fill_sh;
    logic [WORD_W-1:0] res;
    fill_sh = {n[2:0], 3'b000};
    top_bit = fill_sh - 6'd1;
    res     = off;
    if ((n != '0) && (n[3] == 1'b0) && off[top_bit]) begin
      res = off | ({WORD_W{1'b1}} << fill_sh);
    end
    return res;
  endfunction

endpackage

// ===== hdl/data_run_list_decoder.sv =====
// top level of the data-run list decoder
// usage:
//   in_* takes the run list one byte per transaction (valid/ready); out_* gives one
//   transaction per run, per zero header (end_of_list) and per bad header (header_error)
//   cfg_* writes sectors_per_cluster (index 0) or bytes_per_sector (index 1); always ready,
//   other indexes are ignored; write only while no run is in flight
// timing:
//   header and field bytes that end nothing take one cycle each
//   the last byte of a run starts a seven-cycle sequence: five cycles of
//   multiply-accumulate (one 16x21 multiplier feeding the shared 64-bit adder,
//   one 16-bit slice of the cluster count per cycle), one cycle where the same adder
//   adds the sign-extended offset to the running position, one cycle to load the result
//   a zero or bad header takes two cycles; in_ready is low while a sequence runs
// output: a result sits in an output register; while it waits for out_ready, bytes
//   that end nothing keep flowing, the next result waits in its load cycle
// reset: synchronous active-low rst_n returns to header parsing with position zero,
//   sectors_per_cluster = 8 and bytes_per_sector = 512
`include "data_run_list_decoder_macros.svh"

module data_run_list_decoder (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [drl_pkg::BYTE_W-1:0]          in_data_byte,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [drl_pkg::WORD_W-1:0]          out_run_start_cluster,
  output logic [drl_pkg::WORD_W-1:0]          out_run_clusters,
  output logic [drl_pkg::WORD_W-1:0]          out_run_bytes,
  output logic                                out_end_of_list,
  output logic                                out_header_error,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [drl_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [drl_pkg::CFG_DAT_W-1:0]       cfg_data
);

  localparam logic [drl_pkg::SIZE_W-1:0] MAX_SIZE = drl_pkg::SIZE_W'(drl_pkg::MAX_FIELD_BYTES);
  localparam logic [2:0] LAST_STEP = 3'(drl_pkg::NCHUNK);

  // sequencer and parse state
  drl_pkg::seq_state_t state_r, state_nxt;
  drl_pkg::phase_t     phase_r, phase_nxt;
  drl_pkg::res_kind_t  res_kind_r, res_kind_nxt;
  logic [drl_pkg::SIZE_W-1:0] left_r, left_nxt;
  logic [drl_pkg::SIZE_W-1:0] lsz_r, lsz_nxt;
  logic [drl_pkg::SIZE_W-1:0] osz_r, osz_nxt;
  logic [drl_pkg::WORD_W-1:0] len_acc_r, len_acc_nxt;
  logic [drl_pkg::WORD_W-1:0] off_acc_r, off_acc_nxt;
  logic [drl_pkg::WORD_W-1:0] running_r;
  logic [drl_pkg::WORD_W-1:0] start_r;
  logic [2:0]                 step_r;

  // configuration
  logic [drl_pkg::SPC_W-1:0]   spc_r;
  logic [drl_pkg::BPS_W-1:0]   bps_r;
  logic [drl_pkg::SCALE_W-1:0] scale_r;

  // output register
  logic                       out_valid_r;
  logic [drl_pkg::WORD_W-1:0] out_start_r, out_clus_r, out_bytes_r;
  logic                       out_eol_r, out_err_r;

  // decode of the accepted byte
  logic                       accept;
  logic                       run_done, hdr_result;
  logic [drl_pkg::SIZE_W-1:0] hdr_lsz, hdr_osz;
  logic [drl_pkg::SIZE_W-1:0] size_sel, left_dec, idx_full;
  logic [drl_pkg::WORD_W-1:0] placed;
  logic [drl_pkg::BYTE_W-1:0] len_bits, off_bits;

  // shared unit
  drl_pkg::unit_ctl_t         ctl;
  logic [drl_pkg::WORD_W-1:0] offset_ext;
  logic [drl_pkg::WORD_W-1:0] sum;
  logic [drl_pkg::WORD_W-1:0] bytes_acc;
  logic                       emit_go;

  assign accept    = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  assign len_bits = in_data_byte & drl_pkg::HDR_LEN_MASK;
  assign off_bits = (in_data_byte & drl_pkg::HDR_OFF_MASK) >> 4;
  assign hdr_lsz  = len_bits[drl_pkg::SIZE_W-1:0];
  assign hdr_osz  = off_bits[drl_pkg::SIZE_W-1:0];

  // byte position inside the little-endian field
  assign size_sel = (phase_r == drl_pkg::PH_LENGTH) ? lsz_r : osz_r;
  assign idx_full = size_sel - left_r;
  assign placed   = drl_pkg::WORD_W'(in_data_byte) << {idx_full[2:0], 3'b000};
  assign left_dec = left_r - 4'd1;

  // parse of one accepted byte
  always_comb begin
    phase_nxt    = phase_r;
    left_nxt     = left_r;
    lsz_nxt      = lsz_r;
    osz_nxt      = osz_r;
    len_acc_nxt  = len_acc_r;
    off_acc_nxt  = off_acc_r;
    res_kind_nxt = res_kind_r;
    run_done     = 1'b0;
    hdr_result   = 1'b0;
    if (accept) begin
      case (phase_r)
        drl_pkg::PH_LENGTH: begin
          len_acc_nxt = len_acc_r | placed;
          left_nxt    = left_dec;
          if (left_dec == '0) begin
            if (osz_r != '0) begin
              phase_nxt = drl_pkg::PH_OFFSET;
              left_nxt  = osz_r;
            end else begin
              phase_nxt    = drl_pkg::PH_HEADER;
              run_done     = 1'b1;
              res_kind_nxt = drl_pkg::RES_RUN;
            end
          end
        end
        drl_pkg::PH_OFFSET: begin
          off_acc_nxt = off_acc_r | placed;
          left_nxt    = left_dec;
          if (left_dec == '0) begin
            phase_nxt    = drl_pkg::PH_HEADER;
            run_done     = 1'b1;
            res_kind_nxt = drl_pkg::RES_RUN;
          end
        end
        default: begin
          phase_nxt = drl_pkg::PH_HEADER;
          if (in_data_byte == '0) begin
            hdr_result   = 1'b1;
            res_kind_nxt = drl_pkg::RES_END;
          end else if ((hdr_lsz > MAX_SIZE) || (hdr_osz > MAX_SIZE)) begin
            hdr_result   = 1'b1;
            res_kind_nxt = drl_pkg::RES_ERR;
          end else begin
            lsz_nxt     = hdr_lsz;
            osz_nxt     = hdr_osz;
            len_acc_nxt = '0;
            off_acc_nxt = '0;
            if (hdr_lsz != '0) begin
              phase_nxt = drl_pkg::PH_LENGTH;
              left_nxt  = hdr_lsz;
            end else begin
              phase_nxt = drl_pkg::PH_OFFSET;
              left_nxt  = hdr_osz;
            end
          end
        end
      endcase
    end
  end

  // sequencer next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      drl_pkg::S_IDLE: begin
        if (run_done) begin
          state_nxt = drl_pkg::S_MUL;
        end else if (hdr_result) begin
          state_nxt = drl_pkg::S_EMIT;
        end
      end
      drl_pkg::S_MUL: begin
        if (step_r == LAST_STEP) begin
          state_nxt = drl_pkg::S_OFF;
        end
      end
      drl_pkg::S_OFF: begin
        state_nxt = drl_pkg::S_EMIT;
      end
      drl_pkg::S_EMIT: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = drl_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = drl_pkg::S_IDLE;
      end
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready    = 1'b0;
    emit_go     = 1'b0;
    ctl.acc_clr = 1'b0;
    ctl.mul_en  = 1'b0;
    ctl.mul_sel = step_r[1:0];
    ctl.add_op  = drl_pkg::ADD_NONE;
    unique case (state_r)
      drl_pkg::S_IDLE: begin
        in_ready = 1'b1;
      end
      drl_pkg::S_MUL: begin
        // step 0 clears the sum, the last step only drains the product
        ctl.acc_clr = (step_r == '0);
        ctl.mul_en  = (step_r != LAST_STEP);
        if (step_r != '0) begin
          ctl.add_op = drl_pkg::ADD_MAC;
        end
      end
      drl_pkg::S_OFF: begin
        if (osz_r != '0) begin
          ctl.add_op = drl_pkg::ADD_OFFSET;
        end
      end
      drl_pkg::S_EMIT: begin
        emit_go = !out_valid_r || out_ready;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  assign offset_ext = drl_pkg::sign_extend(off_acc_r, osz_r);

  drl_unit u_unit (
    .clk        (clk),
    .ctl        (ctl),
    .clusters   (len_acc_r),
    .scale      (scale_r),
    .running    (running_r),
    .offset_ext (offset_ext),
    .sum        (sum),
    .bytes_acc  (bytes_acc)
  );

  // control and parse state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= drl_pkg::S_IDLE;
      phase_r    <= drl_pkg::PH_HEADER;
      res_kind_r <= drl_pkg::RES_RUN;
      left_r     <= '0;
      lsz_r      <= '0;
      osz_r      <= '0;
      len_acc_r  <= '0;
      off_acc_r  <= '0;
      running_r  <= '0;
      step_r     <= '0;
    end else begin
      state_r    <= state_nxt;
      phase_r    <= phase_nxt;
      res_kind_r <= res_kind_nxt;
      left_r     <= left_nxt;
      lsz_r      <= lsz_nxt;
      osz_r      <= osz_nxt;
      len_acc_r  <= len_acc_nxt;
      off_acc_r  <= off_acc_nxt;
      if (state_r == drl_pkg::S_MUL) begin
        step_r <= step_r + 3'd1;
      end else begin
        step_r <= '0;
      end
      // zero header clears the position, offset add moves it
      if (hdr_result && (res_kind_nxt == drl_pkg::RES_END)) begin
        running_r <= '0;
      end else if (ctl.add_op == drl_pkg::ADD_OFFSET) begin
        running_r <= sum;
      end
    end
  end

  // start cluster of the run, zero for a sparse run
  always_ff @(posedge clk) begin
    if (state_r == drl_pkg::S_OFF) begin
      start_r <= (osz_r != '0) ? sum : '0;
    end
  end

  // configuration registers and the cluster-to-byte scale
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spc_r <= drl_pkg::SPC_RESET;
      bps_r <= drl_pkg::BPS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        drl_pkg::REG_SECTORS_PER_CLUSTER: spc_r <= cfg_data[drl_pkg::SPC_W-1:0];
        drl_pkg::REG_BYTES_PER_SECTOR:    bps_r <= cfg_data[drl_pkg::BPS_W-1:0];
        default: begin
          spc_r <= spc_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    scale_r <= drl_pkg::SCALE_W'(spc_r) * drl_pkg::SCALE_W'(bps_r);
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_go) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      out_start_r <= (res_kind_r == drl_pkg::RES_RUN) ? start_r   : '0;
      out_clus_r  <= (res_kind_r == drl_pkg::RES_RUN) ? len_acc_r : '0;
      out_bytes_r <= (res_kind_r == drl_pkg::RES_RUN) ? bytes_acc : '0;
      out_eol_r   <= (res_kind_r == drl_pkg::RES_END);
      out_err_r   <= (res_kind_r == drl_pkg::RES_ERR);
    end
  end

  assign out_valid             = out_valid_r;
  assign out_run_start_cluster = out_start_r;
  assign out_run_clusters      = out_clus_r;
  assign out_run_bytes         = out_bytes_r;
  assign out_end_of_list       = out_eol_r;
  assign out_header_error      = out_err_r;

  // checks
  `DRL_ASSERT_NOW(a_one_flag, out_valid_r, !(out_eol_r && out_err_r))
  `DRL_ASSERT_NEXT(a_zero_hdr_clears, accept && (phase_r != drl_pkg::PH_LENGTH) && (phase_r != drl_pkg::PH_OFFSET) && (in_data_byte == '0), running_r == '0)
  `DRL_ASSERT_NEXT(a_mul_runs_through, (state_r == drl_pkg::S_MUL) && (step_r != LAST_STEP), state_r == drl_pkg::S_MUL)
  `DRL_ASSERT_NOW(a_field_count, (phase_r == drl_pkg::PH_LENGTH) || (phase_r == drl_pkg::PH_OFFSET), (left_r != '0) && (left_r <= MAX_SIZE))

endmodule

// ===== hdl/drl_unit.sv =====
// shared multiply stage and 64-bit adder of the data-run list decoder
module drl_unit (
  input  logic                              clk,
  input  drl_pkg::unit_ctl_t                ctl,
  input  logic [drl_pkg::WORD_W-1:0]        clusters,
  input  logic [drl_pkg::SCALE_W-1:0]       scale,
  input  logic [drl_pkg::WORD_W-1:0]        running,
  input  logic [drl_pkg::WORD_W-1:0]        offset_ext,
  output logic [drl_pkg::WORD_W-1:0]        sum,
  output logic [drl_pkg::WORD_W-1:0]        bytes_acc
);

  logic [drl_pkg::WORD_W-1:0]  chunk_shift;
  logic [drl_pkg::CHUNK_W-1:0] chunk;
  logic [drl_pkg::PROD_W-1:0]  prod_r;
  logic [1:0]                  prod_sel_r;
  logic [drl_pkg::WORD_W-1:0]  prod_shift;
  logic [drl_pkg::WORD_W-1:0]  opa;
  logic [drl_pkg::WORD_W-1:0]  opb;
  logic [drl_pkg::WORD_W-1:0]  acc_r;

  // pick one 16-bit slice of the cluster count
  assign chunk_shift = clusters >> {ctl.mul_sel, 4'b0000};
  assign chunk       = chunk_shift[drl_pkg::CHUNK_W-1:0];

  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod_r     <= drl_pkg::PROD_W'(chunk) * drl_pkg::PROD_W'(scale);
      prod_sel_r <= ctl.mul_sel;
    end
  end

  assign prod_shift = drl_pkg::WORD_W'(prod_r) << {prod_sel_r, 4'b0000};

  always_comb begin
    unique case (ctl.add_op)
      drl_pkg::ADD_OFFSET: begin
        opa = running;
        opb = offset_ext;
      end
      drl_pkg::ADD_MAC: begin
        opa = acc_r;
        opb = prod_shift;
      end
      default: begin
        opa = acc_r;
        opb = '0;
      end
    endcase
  end

  assign sum = opa + opb;

  always_ff @(posedge clk) begin
    if (ctl.acc_clr) begin
      acc_r <= '0;
    end else if (ctl.add_op == drl_pkg::ADD_MAC) begin
      acc_r <= sum;
    end
  end

  assign bytes_acc = acc_r;

endmodule

// ===== tb/sv/testbench.sv =====
// self-checking testbench of the data-run list decoder: directed and random run lists
`timescale 1ns / 1ps

module testbench;

  // zero header closes a run list
  localparam logic [drl_pkg::BYTE_W-1:0] END_HEADER = 8'h00;
  // register indexes the block has no register behind
  localparam logic [drl_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [drl_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;
  // cycles allowed after the last result for a sequence still in flight
  localparam int unsigned TAIL_CYCLES = 16;
  // cycles without any transaction before the run is declared hung
  localparam int unsigned WATCHDOG_LIMIT = 2000;

  typedef struct packed {
    logic [drl_pkg::WORD_W-1:0] start_cluster;
    logic [drl_pkg::WORD_W-1:0] clusters;
    logic [drl_pkg::WORD_W-1:0] byte_count;
    logic                       end_of_list;
    logic                       header_error;
  } run_result_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic [drl_pkg::BYTE_W-1:0]    in_data_byte = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic [drl_pkg::WORD_W-1:0]    out_run_start_cluster;
  logic [drl_pkg::WORD_W-1:0]    out_run_clusters;
  logic [drl_pkg::WORD_W-1:0]    out_run_bytes;
  logic                          out_end_of_list;
  logic                          out_header_error;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [drl_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [drl_pkg::CFG_DAT_W-1:0] cfg_data = '0;

  // decoder model state, mirrors the block
  drl_pkg::phase_t            parse_phase = drl_pkg::PH_HEADER;
  logic [drl_pkg::SIZE_W-1:0] bytes_left = '0;
  logic [drl_pkg::SIZE_W-1:0] length_size = '0;
  logic [drl_pkg::SIZE_W-1:0] offset_size = '0;
  logic [drl_pkg::WORD_W-1:0] length_acc = '0;
  logic [drl_pkg::WORD_W-1:0] offset_acc = '0;
  logic [drl_pkg::WORD_W-1:0] cluster_pos = '0;
  logic [drl_pkg::SPC_W-1:0]  sectors_per_cluster = drl_pkg::SPC_RESET;
  logic [drl_pkg::BPS_W-1:0]  bytes_per_sector = drl_pkg::BPS_RESET;

  // decoded runs not yet seen on the result channel
  run_result_t pending_runs[$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned items_sent = 0;
  int unsigned error_count = 0;
  int unsigned quiet_cycles = 0;

  data_run_list_decoder dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_data_byte         (in_data_byte),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_run_start_cluster(out_run_start_cluster),
    .out_run_clusters     (out_run_clusters),
    .out_run_bytes        (out_run_bytes),
    .out_end_of_list      (out_end_of_list),
    .out_header_error     (out_header_error),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // append one expected result behind the others
  function automatic void queue_result(input run_result_t res);
    pending_runs.insert(pending_runs.size(), res);
  endfunction

  // close the current run: apply the signed offset and queue its result
  function automatic void emit_run();
    run_result_t                res;
    logic [drl_pkg::WORD_W-1:0] delta;
    res = '0;
    res.clusters = length_acc;
    res.byte_count = length_acc * {56'd0, sectors_per_cluster} * {51'd0, bytes_per_sector};
    // sparse run: no offset field, position untouched, start reported as zero
    if (offset_size != '0) begin
      delta = offset_acc;
      if (offset_size < drl_pkg::MAX_FIELD_BYTES && delta[8 * offset_size - 1])
        delta = delta | ({drl_pkg::WORD_W{1'b1}} << (8 * offset_size));
      cluster_pos = cluster_pos + delta;
      res.start_cluster = cluster_pos;
    end
    queue_result(res);
    parse_phase = drl_pkg::PH_HEADER;
    bytes_left = '0;
  endfunction

  // advance the decoder model by one accepted byte
  function automatic void decode_byte(input logic [drl_pkg::BYTE_W-1:0] data);
    logic [drl_pkg::SIZE_W-1:0] slot;
    logic [drl_pkg::SIZE_W-1:0] lsz;
    logic [drl_pkg::SIZE_W-1:0] osz;
    run_result_t                res;
    case (parse_phase)
      drl_pkg::PH_LENGTH: begin
        slot = length_size - bytes_left;
        length_acc = length_acc | ({56'd0, data} << (8 * slot[2:0]));
        bytes_left = bytes_left - 4'd1;
        if (bytes_left == '0) begin
          if (offset_size != '0) begin
            parse_phase = drl_pkg::PH_OFFSET;
            bytes_left = offset_size;
          end else begin
            emit_run();
          end
        end
      end
      drl_pkg::PH_OFFSET: begin
        slot = offset_size - bytes_left;
        offset_acc = offset_acc | ({56'd0, data} << (8 * slot[2:0]));
        bytes_left = bytes_left - 4'd1;
        if (bytes_left == '0) emit_run();
      end
      default: begin
        parse_phase = drl_pkg::PH_HEADER;
        res = '0;
        lsz = drl_pkg::SIZE_W'(data & drl_pkg::HDR_LEN_MASK);
        osz = drl_pkg::SIZE_W'((data & drl_pkg::HDR_OFF_MASK) >> 4);
        if (data == END_HEADER) begin
          cluster_pos = '0;
          res.end_of_list = 1'b1;
          queue_result(res);
        end else if (lsz > drl_pkg::MAX_FIELD_BYTES || osz > drl_pkg::MAX_FIELD_BYTES) begin
          // position kept, next byte is a header again
          res.header_error = 1'b1;
          queue_result(res);
        end else begin
          length_size = lsz;
          offset_size = osz;
          length_acc = '0;
          offset_acc = '0;
          if (lsz != '0) begin
            parse_phase = drl_pkg::PH_LENGTH;
            bytes_left = lsz;
          end else begin
            parse_phase = drl_pkg::PH_OFFSET;
            bytes_left = osz;
          end
        end
      end
    endcase
  endfunction

  // one input transaction, with a random idle gap before it
  task automatic send_byte(input logic [drl_pkg::BYTE_W-1:0] data);
    if ($urandom_range(99, 0) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99, 0) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_data_byte <= data;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    // valid stays up: the next call either keeps it or drops it
    decode_byte(data);
    items_sent++;
  endtask

  // hold the sender until every decoded result has left the block
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_runs.size() != 0) @(posedge clk);
  endtask

  // finish any partial run so the model sits on a header boundary
  task automatic close_run();
    while (parse_phase != drl_pkg::PH_HEADER)
      send_byte(drl_pkg::BYTE_W'($urandom_range(255, 0)));
  endtask

  // idle block: no partial run, no result pending, sequence fully retired
  task automatic settle_block();
    close_run();
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  // one register write transaction, only while the block is idle
  task automatic write_reg(input logic [drl_pkg::CFG_IDX_W-1:0] idx,
                           input logic [drl_pkg::CFG_DAT_W-1:0] data);
    settle_block();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == drl_pkg::REG_SECTORS_PER_CLUSTER)
      sectors_per_cluster = data[drl_pkg::SPC_W-1:0];
    else if (idx == drl_pkg::REG_BYTES_PER_SECTOR)
      bytes_per_sector = data[drl_pkg::BPS_W-1:0];
  endtask

  // field extremes: widest offset, negative and positive one-byte offsets
  task automatic test_run_fields();
    // one-byte length, eight-byte offset of all ones: position wraps to max
    send_byte(8'h81);
    send_byte(8'hFF);
    repeat (drl_pkg::MAX_FIELD_BYTES) send_byte(8'hFF);
    // zero length value, offset with top bit set steps backward
    send_byte(8'h11);
    send_byte(8'h00);
    send_byte(8'h80);
    // offset just below the sign threshold
    send_byte(8'h11);
    send_byte(8'h01);
    send_byte(8'h7F);
    settle_block();
  endtask

  // sparse run, zero length size, bad nibbles and the zero header
  task automatic test_header_cases();
    send_byte(8'h01);
    send_byte(8'h05);
    send_byte(8'h10);
    send_byte(8'h7F);
    // offset nibble too big, then length nibble, then both
    send_byte(8'h91);
    send_byte(8'h1A);
    send_byte(8'hFF);
    send_byte(END_HEADER);
    settle_block();
  endtask

  // register extremes, out-of-range values and unused indexes
  task automatic test_register_writes();
    // zero sectors per cluster: byte length must be zero
    write_reg(drl_pkg::REG_SECTORS_PER_CLUSTER, 13'd0);
    send_byte(8'h11);
    send_byte(8'h03);
    send_byte(8'h01);
    write_reg(drl_pkg::REG_SECTORS_PER_CLUSTER, 13'd128);
    write_reg(drl_pkg::REG_BYTES_PER_SECTOR, 13'd4096);
    send_byte(8'h11);
    send_byte(8'hFF);
    send_byte(8'h01);
    // all data bits set: sectors register keeps its low byte
    write_reg(drl_pkg::REG_SECTORS_PER_CLUSTER, 13'h1FFF);
    write_reg(drl_pkg::REG_BYTES_PER_SECTOR, 13'h1FFF);
    send_byte(8'h21);
    send_byte(8'hFF);
    send_byte(8'hFF);
    send_byte(8'h02);
    write_reg(drl_pkg::REG_SECTORS_PER_CLUSTER, 13'd1);
    write_reg(drl_pkg::REG_BYTES_PER_SECTOR, 13'd256);
    // writes to unused indexes must leave both registers alone
    write_reg(REG_SPARE_LO, drl_pkg::CFG_DAT_W'($urandom_range(8191, 0)));
    write_reg(REG_SPARE_HI, drl_pkg::CFG_DAT_W'($urandom_range(8191, 0)));
    send_byte(8'h01);
    send_byte(8'h07);
    send_byte(END_HEADER);
    settle_block();
  endtask

  // random run lists, mostly well formed, with noise and broken runs
  task automatic test_random_lists(input int unsigned send_pct, input int unsigned recv_pct,
                                   input int unsigned item_goal);
    int unsigned first_item;
    int unsigned next_cfg;
    int unsigned dice;
    int unsigned lsz;
    int unsigned osz;
    int unsigned field_bytes;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    first_item = items_sent;
    next_cfg = items_sent;
    while (items_sent - first_item < item_goal) begin
      // new register setting now and then, on a run boundary
      if (items_sent >= next_cfg) begin
        write_reg(drl_pkg::REG_SECTORS_PER_CLUSTER,
                  drl_pkg::CFG_DAT_W'($urandom_range(128, 1)));
        write_reg(drl_pkg::REG_BYTES_PER_SECTOR,
                  drl_pkg::CFG_DAT_W'($urandom_range(4096, 256)));
        next_cfg = items_sent + 50;
      end
      dice = $urandom_range(99, 0);
      if (dice < 6) begin
        // noise byte wherever the parser stands
        send_byte(drl_pkg::BYTE_W'($urandom_range(255, 0)));
      end else if (dice < 12) begin
        // header with at least one oversized nibble
        lsz = $urandom_range(15, 0);
        osz = $urandom_range(15, 0);
        if ($urandom_range(1, 0) != 0) lsz = $urandom_range(15, drl_pkg::MAX_FIELD_BYTES + 1);
        else osz = $urandom_range(15, drl_pkg::MAX_FIELD_BYTES + 1);
        send_byte({osz[3:0], lsz[3:0]});
      end else if (dice < 22) begin
        send_byte(END_HEADER);
      end else begin
        // well-formed run with random content, sometimes cut short
        lsz = $urandom_range(drl_pkg::MAX_FIELD_BYTES, 0);
        osz = $urandom_range(drl_pkg::MAX_FIELD_BYTES, 0);
        field_bytes = lsz + osz;
        if ($urandom_range(19, 0) == 0 && field_bytes != 0)
          field_bytes = $urandom_range(field_bytes - 1, 0);
        send_byte({osz[3:0], lsz[3:0]});
        repeat (field_bytes) send_byte(drl_pkg::BYTE_W'($urandom_range(255, 0)));
      end
      // now and then the sender holds off until the result channel is empty
      if ($urandom_range(15, 0) == 0) drain_results();
    end
    settle_block();
  endtask

  // result channel stalls
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99, 0) >= recv_idle_pct);
  end

  // compare every result transaction with the oldest decoded run
  always @(posedge clk) begin
    run_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_runs.size() == 0) begin
        $error("result transaction with no decoded run pending");
        error_count++;
      end else begin
        want = pending_runs.pop_front();
        if (out_run_start_cluster !== want.start_cluster) begin
          $error("run_start_cluster: expected %h, got %h", want.start_cluster,
                 out_run_start_cluster);
          error_count++;
        end
        if (out_run_clusters !== want.clusters) begin
          $error("run_clusters: expected %h, got %h", want.clusters, out_run_clusters);
          error_count++;
        end
        if (out_run_bytes !== want.byte_count) begin
          $error("run_bytes: expected %h, got %h", want.byte_count, out_run_bytes);
          error_count++;
        end
        if (out_end_of_list !== want.end_of_list) begin
          $error("end_of_list: expected %b, got %b", want.end_of_list, out_end_of_list);
          error_count++;
        end
        if (out_header_error !== want.header_error) begin
          $error("header_error: expected %b, got %b", want.header_error, out_header_error);
          error_count++;
        end
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    // reset held low at the start, once
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // sender idles rarely, receiver often
    send_idle_pct = 10;
    recv_idle_pct = 79;
    test_run_fields();
    test_header_cases();
    test_register_writes();
    test_random_lists(10, 79, 134);
    // sender idles often, receiver rarely
    test_random_lists(79, 10, 133);
    // no idling on either side
    test_random_lists(0, 0, 133);
    settle_block();
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
